### rtl/assert_macros.svh
// assertion macros used by page_framebuffer_raster_ops
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

### rtl/pfro_pkg.sv
// package for the page framebuffer raster ops block
// no dependencies
package pfro_pkg;
    localparam int DEF_COLUMNS = 128;
    localparam int DEF_ROWS = 64;
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_FILL = 3'd1;
    localparam logic [2:0] CMD_LINE = 3'd2;
    localparam logic [2:0] CMD_OUTLINE = 3'd3;
    localparam logic [2:0] CMD_READ = 3'd4;

    // one span pass: column range and row range to set or clear
    typedef struct packed {
        logic       set;
        logic [7:0] x0;
        logic [7:0] x1;
        logic [7:0] y0;
        logic [7:0] y1;
    } pfro_span_t;

    // mask of rows lo..hi inside one page byte
    function automatic logic [7:0] page_mask(input logic [2:0] lo, input logic [2:0] hi);
        page_mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    endfunction
endpackage

### rtl/pfro_store.sv
// framebuffer memory, one write and one registered read port
// depends on pfro_pkg
module pfro_store
    import pfro_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/page_framebuffer_raster_ops.sv
// page framebuffer raster ops: clear/fill/line/outline/read on a paged store
// one command at a time; each touched byte is read then written
// a draw command holds the input until every byte of all its spans is written
// a read passes S_RDWAIT and S_RDOUT before its word is shown; input waits until that word leaves
// after reset a clearing pass writes zero to all COLUMNS*pages bytes, one per cycle
// no command is accepted during that pass; depends on pfro_pkg, pfro_store, assert_macros.svh
`include "assert_macros.svh"
module page_framebuffer_raster_ops
    import pfro_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS = DEF_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], x_start[9:3], y_start[15:10], x_end[22:16], y_end[28:23],
    // read_column[35:29], read_page[38:36]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0]
    output logic [7:0]  m_tdata
);
    localparam int PAGES = (ROWS + 7) / 8;
    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [2:0] {S_INIT, S_IDLE, S_RD, S_WR, S_RDWAIT, S_RDOUT, S_OUT} state_t;

    state_t       state_reg;
    logic [AW:0]  init_reg;
    pfro_span_t   spans_reg [4];
    logic [3:0]   act_reg;
    logic [1:0]   sp_reg;
    logic [7:0]   col_reg;
    logic [4:0]   pg_reg;
    logic [7:0]   out_reg;
    logic         outv_reg;
    logic         rdout_reg;
    logic [AW-1:0] addr_reg;

    logic [2:0] cmd;
    logic [6:0] xs, xe, rc;
    logic [5:0] ys, ye;
    logic [2:0] rp;
    assign cmd = s_tdata[2:0];
    assign xs = s_tdata[9:3];
    assign ys = s_tdata[15:10];
    assign xe = s_tdata[22:16];
    assign ye = s_tdata[28:23];
    assign rc = s_tdata[35:29];
    assign rp = s_tdata[38:36];

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    pfro_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    pfro_span_t cur;
    logic [7:0] y1c;
    logic [4:0] p0, p1;
    logic [2:0] lo, hi;
    logic [7:0] mask;
    logic [AW+8:0] addr_full;
    assign cur = spans_reg[sp_reg];
    assign y1c = (9'(cur.y1) >= 9'(ROWS)) ? 8'(ROWS - 1) : cur.y1;
    assign p0 = cur.y0[7:3];
    assign p1 = y1c[7:3];
    assign lo = (pg_reg == p0) ? cur.y0[2:0] : 3'd0;
    assign hi = (pg_reg == p1) ? y1c[2:0] : 3'd7;
    assign mask = page_mask(lo, hi);
    assign addr_full = (AW+9)'(col_reg) * (AW+9)'(PAGES) + (AW+9)'(pg_reg);

    assign raddr = addr_full[AW-1:0];
    always_comb
    begin
        we = 1'b0;
        waddr = addr_reg;
        wdata = cur.set ? (rdata | mask) : (rdata & ~mask);
        if (state_reg == S_INIT)
        begin
            we = 1'b1;
            waddr = init_reg[AW-1:0];
            wdata = 8'h00;
        end
        else if (state_reg == S_WR)
        begin
            we = 1'b1;
        end
    end

    // does each span cover anything inside the buffer
    logic [3:0] live;
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            live[i] = act_reg[i] && (9'(spans_reg[i].x0) < 9'(COLUMNS))
                      && (9'(spans_reg[i].y0) < 9'(ROWS))
                      && (spans_reg[i].y0 <= spans_reg[i].y1);
        end
    end

    logic [1:0] nsp;
    logic       nfound;
    always_comb
    begin
        nfound = 1'b0;
        nsp = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (live[i] && 2'(i) > sp_reg)
            begin
                nfound = 1'b1;
                nsp = 2'(i);
            end
        end
    end

    logic [1:0] fsp;
    logic       ffound;
    always_comb
    begin
        ffound = 1'b0;
        fsp = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (live[i])
            begin
                ffound = 1'b1;
                fsp = 2'(i);
            end
        end
    end

    logic last_pg, last_col;
    assign last_pg = (pg_reg == p1);
    assign last_col = (col_reg == cur.x1) || (col_reg == 8'(COLUMNS - 1));

    assign s_tready = (state_reg == S_IDLE) && !outv_reg;
    assign m_tvalid = outv_reg;
    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg <= '0;
            act_reg <= '0;
            sp_reg <= '0;
            outv_reg <= 1'b0;
            rdout_reg <= 1'b0;
        end
        else
        begin
            if (outv_reg && m_tready)
            begin
                outv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == (AW+1)'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        act_reg <= '0;
                        if (cmd == CMD_READ)
                        begin
                            rdout_reg <= (32'(rc) < COLUMNS) && (32'(rp) < PAGES);
                            col_reg <= {1'b0, rc};
                            pg_reg <= {2'b0, rp};
                            state_reg <= S_RDWAIT;
                        end
                        else if (cmd < CMD_READ && xs <= xe && ys <= ye)
                        begin
                            spans_reg[0] <= '{cmd != CMD_CLEAR, {1'b0, xs},
                                (cmd == CMD_LINE && ys != ye) ? {1'b0, xs} : {1'b0, xe},
                                {2'b0, ys},
                                (cmd == CMD_CLEAR || cmd == CMD_FILL
                                 || (cmd == CMD_LINE && ys != ye)) ? {2'b0, ye} : {2'b0, ys}};
                            spans_reg[1] <= '{1'b1, {1'b0, xs}, {1'b0, xe}, {2'b0, ye}, {2'b0, ye}};
                            spans_reg[2] <= '{1'b1, {1'b0, xs}, {1'b0, xs}, {2'b0, ys}, {2'b0, ye}};
                            spans_reg[3] <= '{1'b1, {1'b0, xe}, {1'b0, xe}, {2'b0, ys}, {2'b0, ye}};
                            act_reg <= (cmd == CMD_OUTLINE) ? 4'b1111 : 4'b0001;
                            sp_reg <= '0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    // pick first live span
                    if (ffound)
                    begin
                        sp_reg <= fsp;
                        col_reg <= spans_reg[fsp].x0;
                        pg_reg <= spans_reg[fsp].y0[7:3];
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    addr_reg <= addr_full[AW-1:0];
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (!last_pg)
                    begin
                        pg_reg <= pg_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                    else if (!last_col)
                    begin
                        col_reg <= col_reg + 1'b1;
                        pg_reg <= p0;
                        state_reg <= S_RD;
                    end
                    else if (nfound)
                    begin
                        sp_reg <= nsp;
                        col_reg <= spans_reg[nsp].x0;
                        pg_reg <= spans_reg[nsp].y0[7:3];
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        act_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_RDWAIT:
                begin
                    state_reg <= S_RDOUT;
                end
                S_RDOUT:
                begin
                    out_reg <= rdout_reg ? rdata : 8'h00;
                    outv_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, s_tready, state_reg == S_IDLE && !outv_reg)
    `ASSERT_NEXT(a_read_gives_out, clk, rst_n, state_reg == S_RDOUT, m_tvalid)
    `ASSERT_IMPLIES(a_write_only_wr, clk, rst_n, we, state_reg == S_WR || state_reg == S_INIT)
    `ASSERT_NEXT(a_rd_then_wr, clk, rst_n, state_reg == S_RD, state_reg == S_WR)
endmodule
